/* rtl/ipv_pkg.sv */
// Shared types, codes and the character classifier for the address text validator.
package ipv_pkg;

  // Verdict codes carried on the result channel.
  localparam logic [1:0] VERDICT_NEITHER = 2'd0;
  localparam logic [1:0] VERDICT_V4      = 2'd1;
  localparam logic [1:0] VERDICT_V6      = 2'd2;

  // Group limits of the two address forms.
  localparam logic [2:0] V4_LAST_SEP   = 3'd3;
  localparam logic [1:0] V4_MAX_DIGITS = 2'd3;
  localparam logic [3:0] V6_LAST_SEP   = 4'd7;
  localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
  localparam logic [9:0] V4_MAX_VALUE  = 10'd255;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [2:0] {
    TK_DEC,
    TK_HEX,
    TK_DOT,
    TK_COLON,
    TK_NUL,
    TK_OTHER,
    TK_END
  } tok_kind_e;

  // One classified beat as it travels through the queue.
  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
  } tok_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic tok_t classify(input logic [7:0] ch, input logic end_req);
    tok_t t;
    t.digit = 4'd0;
    if (end_req) begin
      t.kind = TK_END;
    end else if (ch == 8'h00) begin
      t.kind = TK_NUL;
    end else if (ch >= "0" && ch <= "9") begin
      t.kind  = TK_DEC;
      t.digit = 4'(ch - 8'h30);
    end else if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) begin
      t.kind = TK_HEX;
    end else if (ch == ".") begin
      t.kind = TK_DOT;
    end else if (ch == ":") begin
      t.kind = TK_COLON;
    end else begin
      t.kind = TK_OTHER;
    end
    return t;
  endfunction

endpackage

/* rtl/ipv_front.sv */
// Front end: accepts character beats and classifies them into tokens for the queue.
module ipv_front import ipv_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       end_req_i,
  input  q_stat_t    q_stat_i,
  output logic       push_o,
  output tok_t       tok_o
);

  // Stall only on a full queue, so stall never looks at valid.
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;
  assign tok_o      = classify(ch_i, end_req_i);

endmodule

/* rtl/ipv_queue.sv */
// Short token queue between the front end and the checker.
module ipv_queue import ipv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  tok_t    push_tok_i,
  input  logic    pop_i,
  output tok_t    head_o,
  output q_stat_t stat_o
);

  tok_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

/* rtl/ipv_back.sv */
// Back end: runs both address checkers on each token up to a NUL and registers the verdict.
module ipv_back import ipv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tok_t       head_i,
  input  q_stat_t    q_stat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o
);

  logic       v4_alive_q, v4_alive_d;
  logic [2:0] v4_groups_q, v4_groups_d;
  logic [1:0] v4_dcnt_q, v4_dcnt_d;
  logic [9:0] v4_val_q, v4_val_d;
  logic       v4_lz_q, v4_lz_d;
  logic       v6_alive_q, v6_alive_d;
  logic [3:0] v6_groups_q, v6_groups_d;
  logic [2:0] v6_dcnt_q, v6_dcnt_d;
  logic       term_q, term_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] verdict_q, verdict_d;
  logic       is_end;
  logic       out_free;
  logic [13:0] v4_mul;

  assign is_end   = (head_i.kind == TK_END);
  assign out_free = !out_valid_q || !out_stall_i;
  // Characters always drain; an end token waits for room in the output register.
  assign pop_o    = !q_stat_i.empty && (!is_end || out_free);

  assign v4_mul = ({4'd0, v4_val_q} << 3) + ({4'd0, v4_val_q} << 1) + {10'd0, head_i.digit};

  always_comb begin
    v4_alive_d  = v4_alive_q;
    v4_groups_d = v4_groups_q;
    v4_dcnt_d   = v4_dcnt_q;
    v4_val_d    = v4_val_q;
    v4_lz_d     = v4_lz_q;
    v6_alive_d  = v6_alive_q;
    v6_groups_d = v6_groups_q;
    v6_dcnt_d   = v6_dcnt_q;
    term_d      = term_q;
    out_valid_d = out_valid_q && out_stall_i;
    verdict_d   = verdict_q;

    if (pop_o) begin
      if (is_end) begin
        out_valid_d = 1'b1;
        if (v4_alive_q && v4_groups_q == V4_LAST_SEP && v4_dcnt_q != 2'd0) begin
          verdict_d = VERDICT_V4;
        end else if (v6_alive_q && v6_groups_q == V6_LAST_SEP && v6_dcnt_q != 3'd0) begin
          verdict_d = VERDICT_V6;
        end else begin
          verdict_d = VERDICT_NEITHER;
        end
        v4_alive_d  = 1'b1;
        v4_groups_d = '0;
        v4_dcnt_d   = '0;
        v4_val_d    = '0;
        v4_lz_d     = 1'b0;
        v6_alive_d  = 1'b1;
        v6_groups_d = '0;
        v6_dcnt_d   = '0;
        term_d      = 1'b0;
      end else if (!term_q) begin
        if (head_i.kind == TK_NUL) begin
          term_d = 1'b1;
        end else begin
          // IPv4 checker
          if (v4_alive_q) begin
            case (head_i.kind)
              TK_DEC: begin
                if (v4_dcnt_q >= V4_MAX_DIGITS) begin
                  v4_alive_d = 1'b0;
                end else begin
                  v4_lz_d   = (v4_dcnt_q == 2'd0) ? (head_i.digit == 4'd0) : v4_lz_q;
                  v4_val_d  = v4_mul[9:0];
                  v4_dcnt_d = v4_dcnt_q + 2'd1;
                  if ((v4_dcnt_d >= 2'd2 && v4_lz_d) || v4_val_d > V4_MAX_VALUE) begin
                    v4_alive_d = 1'b0;
                  end
                end
              end
              TK_DOT: begin
                if (v4_dcnt_q == 2'd0 || v4_groups_q >= V4_LAST_SEP) begin
                  v4_alive_d = 1'b0;
                end else begin
                  v4_groups_d = v4_groups_q + 3'd1;
                  v4_dcnt_d   = '0;
                  v4_val_d    = '0;
                  v4_lz_d     = 1'b0;
                end
              end
              default: begin
                v4_alive_d = 1'b0;
              end
            endcase
          end
          // IPv6 checker
          if (v6_alive_q) begin
            case (head_i.kind)
              TK_DEC, TK_HEX: begin
                if (v6_dcnt_q >= V6_MAX_DIGITS) begin
                  v6_alive_d = 1'b0;
                end else begin
                  v6_dcnt_d = v6_dcnt_q + 3'd1;
                end
              end
              TK_COLON: begin
                if (v6_dcnt_q == 3'd0 || v6_groups_q >= V6_LAST_SEP) begin
                  v6_alive_d = 1'b0;
                end else begin
                  v6_groups_d = v6_groups_q + 4'd1;
                  v6_dcnt_d   = '0;
                end
              end
              default: begin
                v6_alive_d = 1'b0;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_alive_q  <= 1'b1;
      v4_groups_q <= '0;
      v4_dcnt_q   <= '0;
      v4_val_q    <= '0;
      v4_lz_q     <= 1'b0;
      v6_alive_q  <= 1'b1;
      v6_groups_q <= '0;
      v6_dcnt_q   <= '0;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v4_alive_q  <= v4_alive_d;
      v4_groups_q <= v4_groups_d;
      v4_dcnt_q   <= v4_dcnt_d;
      v4_val_q    <= v4_val_d;
      v4_lz_q     <= v4_lz_d;
      v6_alive_q  <= v6_alive_d;
      v6_groups_q <= v6_groups_d;
      v6_dcnt_q   <= v6_dcnt_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

/* rtl/ip_address_text_validator_unit.sv */
// Top level of the IPv4 / IPv6 address text validator.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i / in_stall_o  ch_i[7:0], end_req_i
//   out      out  out_valid_o / out_stall_i verdict_o[1:0]
//
// One input beat is taken every cycle while the four-entry token queue has room.
// An end beat's token is written into the queue when the beat is accepted; from
// the queue head it moves through the checker into the output register, which
// holds the verdict.
// Reset (rst_ni low, asynchronous) empties the queue and returns both checkers
// to their start state. A stalled verdict holds the output register; character
// beats keep draining behind it, and only an end beat waits for room.
module ip_address_text_validator_unit import ipv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       end_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o
);

  q_stat_t q_stat;
  tok_t    push_tok;
  tok_t    head_tok;
  logic    push;
  logic    pop;

  // Classify each accepted beat and push it.
  ipv_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .end_req_i  (end_req_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .tok_o      (push_tok)
  );

  // Decouple the two sides so either can stall alone.
  ipv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .pop_i      (pop),
    .head_o     (head_tok),
    .stat_o     (q_stat)
  );

  // Advance both form checkers and register the verdict.
  ipv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_tok),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o)
  );

  // A queue can never be full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // An accepted beat lands in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !q_stat.empty)
    else $error("accepted beat missing from queue");

  // Only defined verdict codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o == VERDICT_NEITHER || verdict_o == VERDICT_V4 ||
                     verdict_o == VERDICT_V6))
    else $error("undefined verdict code");

  // Popping requires a token in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule
